@@ sv/rne_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, letter codes and digit pattern tables for the Roman numeral encoder.
package rne_pkg;

  typedef logic [3:0] digit_t;

  // One classified request: special flags plus the three decimal digits.
  typedef struct packed {
    logic   err;
    logic   thou;
    digit_t hund;
    digit_t tens;
    digit_t ones;
  } item_t;

  // Decimal position within the number.
  typedef logic [1:0] pos_t;
  localparam pos_t POS_HUND = 2'd0;
  localparam pos_t POS_TENS = 2'd1;
  localparam pos_t POS_ONES = 2'd2;

  // Symbol within one position: unit, five or ten letter.
  typedef logic [1:0] sym_t;
  localparam sym_t SYM_UNIT = 2'd0;
  localparam sym_t SYM_FIVE = 2'd1;
  localparam sym_t SYM_TEN  = 2'd2;

  typedef logic [6:0] ascii_t;
  localparam ascii_t CH_NONE = 7'h00;
  localparam ascii_t CH_I    = 7'h49;
  localparam ascii_t CH_V    = 7'h56;
  localparam ascii_t CH_X    = 7'h58;
  localparam ascii_t CH_L    = 7'h4C;
  localparam ascii_t CH_C    = 7'h43;
  localparam ascii_t CH_D    = 7'h44;
  localparam ascii_t CH_M    = 7'h4D;

  localparam logic [9:0] MAX_VALUE = 10'd1000;

  // Number of letters a digit expands to.
  function automatic logic [2:0] digit_len(digit_t d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:               n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:   n = 3'd2;
      4'd3, 4'd7:               n = 3'd3;
      4'd8:                     n = 3'd4;
      default:                  n = 3'd0;
    endcase
    return n;
  endfunction

  // Symbol at letter slot i of a digit's pattern.
  function automatic sym_t digit_sym(digit_t d, logic [1:0] i);
    sym_t s;
    case (d)
      4'd4:                     s = (i == 2'd0) ? SYM_UNIT : SYM_FIVE;
      4'd5, 4'd6, 4'd7, 4'd8:   s = (i == 2'd0) ? SYM_FIVE : SYM_UNIT;
      4'd9:                     s = (i == 2'd0) ? SYM_UNIT : SYM_TEN;
      default:                  s = SYM_UNIT;
    endcase
    return s;
  endfunction

  // Letter for a symbol at a position.
  function automatic ascii_t place_letter(pos_t p, sym_t s);
    ascii_t c;
    case (p)
      POS_HUND: c = (s == SYM_UNIT) ? CH_C : (s == SYM_FIVE) ? CH_D : CH_M;
      POS_TENS: c = (s == SYM_UNIT) ? CH_X : (s == SYM_FIVE) ? CH_L : CH_C;
      default:  c = (s == SYM_UNIT) ? CH_I : (s == SYM_FIVE) ? CH_V : CH_X;
    endcase
    return c;
  endfunction

endpackage

@@ sv/rne_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts values, flags special cases and splits them into decimal digits.
module rne_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [9:0]    value,
  input  logic          push,
  output logic          full,
  output rne_pkg::item_t item,
  output logic          item_valid,
  input  logic          item_ready
);
  import rne_pkg::*;

  logic       s1_valid;
  logic       s1_err;
  logic       s1_thou;
  digit_t     s1_hund;
  logic [6:0] s1_rem;
  logic       s2_valid;
  item_t      s2_item;

  logic       s1_load;
  logic       s2_load;
  logic       accept;
  digit_t     hund;
  logic [9:0] hbase;
  digit_t     tens;
  logic [6:0] tbase;

  assign s2_load = !s2_valid || item_ready;
  assign s1_load = !s1_valid || s2_load;
  assign full    = !s1_load;
  assign accept  = push && s1_load;

  // Hundreds digit by parallel threshold compares.
  always_comb begin
    hund  = '0;
    hbase = '0;
    for (int k = 1; k < 10; k++) begin
      if (value >= 10'(k * 100)) begin
        hund  = 4'(k);
        hbase = 10'(k * 100);
      end
    end
  end

  // Tens digit of the remainder, same scheme.
  always_comb begin
    tens  = '0;
    tbase = '0;
    for (int k = 1; k < 10; k++) begin
      if (s1_rem >= 7'(k * 10)) begin
        tens  = 4'(k);
        tbase = 7'(k * 10);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= push;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err  <= (value == '0) || (value > MAX_VALUE);
      s1_thou <= (value == MAX_VALUE);
      s1_hund <= hund;
      s1_rem  <= 7'(value - hbase);
    end
    if (s2_load && s1_valid) begin
      s2_item.err  <= s1_err;
      s2_item.thou <= s1_thou;
      s2_item.hund <= s1_hund;
      s2_item.tens <= tens;
      s2_item.ones <= 4'(s1_rem - tbase);
    end
  end

  assign item       = s2_item;
  assign item_valid = s2_valid;

endmodule

@@ sv/rne_fifo.sv @@
`timescale 1ns / 1ps
// Short queue of classified requests between front end and letter sequencer.
module rne_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  rne_pkg::item_t wr_item,
  input  logic           wr_valid,
  output logic           wr_ready,
  output rne_pkg::item_t rd_item,
  output logic           rd_valid,
  input  logic           rd_ready
);
  import rne_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

@@ sv/rne_back.sv @@
`timescale 1ns / 1ps
// Letter sequencer: walks a request's digits, one letter per cycle unless stalled.
module rne_back (
  input  logic           clk,
  input  logic           rst,
  input  rne_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  output logic [6:0]     letter,
  output logic           last,
  output logic           range_error,
  output logic           empty,
  input  logic           pop
);
  import rne_pkg::*;

  logic       active;
  item_t      cur;
  pos_t       pos;
  logic [1:0] idx;
  logic       out_valid;
  ascii_t     out_letter;
  logic       out_last;
  logic       out_err;

  digit_t     dsel;
  logic [2:0] dlen;
  logic       more_here;
  logic       has_later;
  pos_t       next_pos;
  logic       cur_last;
  ascii_t     cur_letter;
  logic       emit;
  logic       load;
  pos_t       first_pos;

  always_comb begin
    case (pos)
      POS_HUND: begin
        dsel      = cur.hund;
        has_later = (cur.tens != '0) || (cur.ones != '0);
        next_pos  = (cur.tens != '0) ? POS_TENS : POS_ONES;
      end
      POS_TENS: begin
        dsel      = cur.tens;
        has_later = (cur.ones != '0);
        next_pos  = POS_ONES;
      end
      default: begin
        dsel      = cur.ones;
        has_later = 1'b0;
        next_pos  = POS_ONES;
      end
    endcase
  end

  assign dlen      = digit_len(dsel);
  assign more_here = ({1'b0, idx} + 3'd1) < dlen;
  assign cur_last  = cur.err || cur.thou || (!more_here && !has_later);

  always_comb begin
    if (cur.err) begin
      cur_letter = CH_NONE;
    end else if (cur.thou) begin
      cur_letter = CH_M;
    end else begin
      cur_letter = place_letter(pos, digit_sym(dsel, idx));
    end
  end

  assign emit       = active && (!out_valid || pop);
  assign item_ready = !active || (emit && cur_last);
  assign load       = item_valid && item_ready;
  assign first_pos  = (item.hund != '0) ? POS_HUND :
                      (item.tens != '0) ? POS_TENS : POS_ONES;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end else if (emit && cur_last) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= item;
      pos <= first_pos;
      idx <= '0;
    end else if (emit) begin
      if (more_here) begin
        idx <= idx + 1'b1;
      end else begin
        pos <= next_pos;
        idx <= '0;
      end
    end
    if (emit) begin
      out_letter <= cur_letter;
      out_last   <= cur_last;
      out_err    <= cur.err;
    end
  end

  assign letter      = out_letter;
  assign last        = out_last;
  assign range_error = out_err;
  assign empty       = !out_valid;

  // An error result stands alone and carries no letter.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_last && (out_letter == CH_NONE))
    else $error("error result not single or carries a letter");

  // While walking a normal number, the position points at a nonzero digit.
  assert property (@(posedge clk) disable iff (rst)
    active && !cur.err && !cur.thou |-> (dsel != '0) && ({1'b0, idx} < dlen))
    else $error("sequencer points outside the digit pattern");

  // A new request is only taken once the previous one has delivered its last letter.
  assert property (@(posedge clk) disable iff (rst)
    load && active |-> emit && cur_last)
    else $error("request loaded over an unfinished one");

  // A letter written while the port held an untaken result means it was lost.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> $stable(out_letter) && $stable(out_last))
    else $error("waiting result overwritten");

endmodule

@@ sv/roman_numeral_encoder.sv @@
`timescale 1ns / 1ps
// Top level of the Roman numeral encoder: front end, request queue, letter sequencer.
//
// Usage:
//   Input channel: drive value and raise push; a request is taken at a rising
//   edge with push high and full low. Valid values are 1 to 1000.
//   Result channel: while empty is low, letter/last/range_error hold the oldest
//   result; it is taken at a rising edge with pop high. One result per letter,
//   last marks the final letter of a numeral. Zero or values above 1000 give a
//   single result with range_error set, letter 0 and last set.
// Path: a request's first letter passes the two front stages, the queue, the
//   sequencer's request register and its output register to the result ports.
// Throughput: the sequencer emits one letter per cycle while pop keeps up, and
//   a numeral has 1 to 12 letters (888 is longest).
//   Requests follow each other with no gap; the front end keeps taking new
//   requests while the sequencer works, until the queue and front stages fill.
// Reset: rst is synchronous, active high; it drops all requests in flight and
//   leaves the result channel empty.
// Stalls: when pop stays low the result is held and the sequencer waits; the
//   queue then fills and full rises to back-pressure the sender.
module roman_numeral_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [9:0] value,
  input  logic       push,
  output logic       full,
  output logic [6:0] letter,
  output logic       last,
  output logic       range_error,
  output logic       empty,
  input  logic       pop
);
  import rne_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t queue_item;
  logic  queue_valid;
  logic  queue_ready;

  // Classifies each request and splits it into digits.
  rne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .push       (push),
    .full       (full),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // Decouples the front end from the letter rate of the sequencer.
  rne_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (front_item),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_item  (queue_item),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready)
  );

  // Emits letters into the output register.
  rne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (queue_item),
    .item_valid  (queue_valid),
    .item_ready  (queue_ready),
    .letter      (letter),
    .last        (last),
    .range_error (range_error),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Roman numeral encoder: directed, back-pressure and random requests.
module testbench;
  import rne_pkg::*;

  // One expected letter as it should appear on the result ports.
  typedef struct packed {
    ascii_t letter;
    logic   last;
    logic   range_error;
  } numeral_char_t;

  logic       clk;
  logic       rst   = 1'b1;
  logic [9:0] value = '0;
  logic       push  = 1'b0;
  logic       pop   = 1'b0;
  logic       full;
  logic [6:0] letter;
  logic       last;
  logic       range_error;
  logic       empty;

  // Letters still owed by the block, oldest first.
  numeral_char_t pending_letters[$];
  int            error_count  = 0;
  // Random idling on both channels; cleared for the final stretch.
  bit            idle_on      = 1'b1;
  // Raised by the stimulus to make the receiver hold off for a long stretch.
  bit            hold_request = 1'b0;

  roman_numeral_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .push        (push),
    .full        (full),
    .letter      (letter),
    .last        (last),
    .range_error (range_error),
    .empty       (empty),
    .pop         (pop)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: expands one decimal digit into letters using the usual
  // subtractive rules, given the unit, five and ten letters of its position.
  // ---------------------------------------------------------------------------
  function automatic void expand_digit(input int d, input ascii_t one, input ascii_t five,
                                       input ascii_t ten, ref ascii_t out_q[$]);
    case (d)
      1, 2, 3: begin
        repeat (d) out_q.push_back(one);
      end
      4: begin
        out_q.push_back(one);
        out_q.push_back(five);
      end
      5, 6, 7, 8: begin
        out_q.push_back(five);
        repeat (d - 5) out_q.push_back(one);
      end
      9: begin
        out_q.push_back(one);
        out_q.push_back(ten);
      end
      default: begin
      end
    endcase
  endfunction

  // Queues the letters a request must produce; the final one carries last.
  function automatic void predict_numeral(input logic [9:0] v);
    ascii_t        chars[$];
    numeral_char_t e;
    int            n;
    if (v == 10'd0 || v > MAX_VALUE) begin
      // Out of range: a single flagged result with no letter.
      e.letter      = CH_NONE;
      e.last        = 1'b1;
      e.range_error = 1'b1;
      pending_letters.push_back(e);
      return;
    end
    if (v == MAX_VALUE) begin
      chars.push_back(CH_M);
    end else begin
      expand_digit(int'(v) / 100,       CH_C, CH_D, CH_M, chars);
      expand_digit((int'(v) / 10) % 10, CH_X, CH_L, CH_C, chars);
      expand_digit(int'(v) % 10,        CH_I, CH_V, CH_X, chars);
    end
    n = chars.size();
    for (int k = 0; k < n; k++) begin
      e.letter      = chars[k];
      e.last        = (k == n - 1);
      e.range_error = 1'b0;
      pending_letters.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called right after a rising edge. An optional idle burst drops
  // push and puts junk on value; then the request is offered until an edge
  // sees push high with full low. Push stays high on return so back-to-back
  // requests never lower and raise it in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [9:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push  <= 1'b0;
      value <= 10'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
    predict_numeral(v);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each popped letter against the oldest expectation and
  // picks pop for the next cycle. Outputs are read at the edge, before the
  // block's registers update, so this sees exactly what the edge consumed.
  // ---------------------------------------------------------------------------
  initial begin
    numeral_char_t e;
    int            stall_left;
    int            hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_letters.size() == 0) begin
          $error("unexpected result: letter %0h last %0b range_error %0b",
                 letter, last, range_error);
          error_count++;
        end else begin
          e = pending_letters.pop_front();
          if (letter !== e.letter) begin
            $error("letter mismatch: expected %0h actual %0h", e.letter, letter);
            error_count++;
          end
          if (last !== e.last) begin
            $error("last mismatch: expected %0b actual %0b", e.last, last);
            error_count++;
          end
          if (range_error !== e.range_error) begin
            $error("range_error mismatch: expected %0b actual %0b",
                   e.range_error, range_error);
            error_count++;
          end
        end
      end
      // Long hold-off, counted here, so the block fills and pushes back.
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Range edges, all-zero and all-one input bits, and every digit in every
  // position, including the subtractive fours and nines and the longest
  // numeral.
  task automatic test_directed();
    logic [9:0] cases[$];
    cases = '{10'd0, 10'd1, 10'd1000, 10'd1001, 10'd1023, 10'd888,
              10'd111, 10'd222, 10'd333, 10'd444, 10'd555, 10'd666, 10'd777, 10'd999,
              10'd4, 10'd9, 10'd40, 10'd90, 10'd400, 10'd900,
              10'd5, 10'd50, 10'd500, 10'd10, 10'd100};
    foreach (cases[i]) send_request(cases[i]);
  endtask

  // Receiver stops for a long stretch while long numerals keep coming.
  task automatic test_back_pressure();
    hold_request = 1'b1;
    repeat (16) send_request($urandom_range(0, 1) ? 10'd888 : 10'($urandom_range(1, 1000)));
  endtask

  // Mostly legal values, with a share of zero and above-range values.
  function automatic logic [9:0] random_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 10'd0;
    if (pick < 12) return 10'($urandom_range(1001, 1023));
    if (pick < 15) return MAX_VALUE;
    return 10'($urandom_range(1, 999));
  endfunction

  task automatic test_random(input int count);
    repeat (count) send_request(random_value());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_pressure();
    test_random(280);

    // Final stretch at full rate on both channels.
    idle_on = 1'b0;
    test_random(40);
    push <= 1'b0;

    while (pending_letters.size() != 0) @(posedge clk);
    // Allow for the pipeline depth so stray extra results get caught.
    repeat (12) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rne_pkg.sv
sv/rne_front.sv
sv/rne_fifo.sv
sv/rne_back.sv
sv/roman_numeral_encoder.sv
tb/testbench.sv
